>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/core/srfc_pkg.sv
// Types, constants and register codes of the sync frame receiver.
`default_nettype none
package srfc_pkg;

  localparam int MAX_FRAME  = 17;
  localparam int POS_W      = $clog2(MAX_FRAME);
  localparam int WP_W       = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W     = POS_W + 1;
  localparam int RAM_DEPTH  = 2 ** ADDR_W;
  localparam int REM_W      = 9;
  localparam int BYTE_POS_W = 5;
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam logic [7:0] LEN_CAP = 8'(MAX_FRAME - 5);

  localparam logic [7:0] SYNC_FIRST_RST    = 8'hFA;
  localparam logic [7:0] SYNC_SECOND_RST   = 8'hAF;
  localparam logic [7:0] MODE_CHECKED_RST  = 8'hF1;
  localparam logic [7:0] MODE_TRAILING_RST = 8'hF2;
  localparam logic [3:0] MAX_PAYLOAD_RST   = 4'd12;

  typedef enum logic [2:0] {
    REG_SYNC_FIRST    = 3'd0,
    REG_SYNC_SECOND   = 3'd1,
    REG_MODE_CHECKED  = 3'd2,
    REG_MODE_TRAILING = 3'd3,
    REG_MAX_PAYLOAD   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] mode_checked;
    logic [7:0] mode_trailing;
    logic [3:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  // drain request: which bank and how many bytes
  typedef struct packed {
    logic            valid;
    logic            bank;
    logic [WP_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  typedef struct packed {
    logic [7:0]            frame_byte;
    logic [BYTE_POS_W-1:0] byte_position;
    logic                  last_byte;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/core/srfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/srfc_front.sv
// Front end: frame parser that stores frame bytes and issues drain requests.
`default_nettype none
module srfc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire srfc_pkg::cfg_t  cfg_i,
  output srfc_pkg::ram_wr_t    wr_o,
  output srfc_pkg::cmd_t       cmd_o,
  output logic                 bank_o
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_MODE, PH_LEN, PH_PAYLOAD, PH_CSUM,
    PH_T_SYNC1, PH_T_SYNC2, PH_T_MODE, PH_T_LEN, PH_T_BODY
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [srfc_pkg::WP_W-1:0]      wp_q, wp_d;
  logic [srfc_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [7:0]                     sum_q, sum_d;
  logic [7:0]                     first_q, first_d;
  logic                           bank_q, bank_d;
  logic                           store, go_idle, restart, room;
  logic [7:0]                     limit;

  assign room  = (wp_q < srfc_pkg::WP_W'(srfc_pkg::MAX_FRAME));
  assign limit = ({4'b0, cfg_i.max_payload} > srfc_pkg::LEN_CAP) ? srfc_pkg::LEN_CAP
                                                                   : {4'b0, cfg_i.max_payload};

  always_comb begin
    phase_d = phase_q;
    wp_d    = wp_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    first_d = first_q;
    bank_d  = bank_q;
    store   = 1'b0;
    go_idle = 1'b0;
    restart = 1'b0;
    cmd_o   = '0;
    if (in_valid_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == cfg_i.sync_first) begin
            store   = 1'b1;
            first_d = rx_byte_i;
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte_i == cfg_i.sync_second) begin
            store   = 1'b1;
            phase_d = PH_MODE;
          end else if (rx_byte_i != cfg_i.sync_first) begin
            go_idle = 1'b1;
          end
        end
        PH_MODE: begin
          if (rx_byte_i == cfg_i.sync_first) begin
            restart = 1'b1;
          end else if (rx_byte_i == cfg_i.mode_checked) begin
            store   = 1'b1;
            phase_d = PH_LEN;
          end else begin
            go_idle = 1'b1;
          end
        end
        PH_LEN: begin
          if (rx_byte_i == cfg_i.sync_first) begin
            restart = 1'b1;
          end else if (rx_byte_i == 8'd0 || rx_byte_i > limit) begin
            go_idle = 1'b1;
          end else begin
            store   = 1'b1;
            rem_d   = srfc_pkg::REM_W'(rx_byte_i);
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          store = 1'b1;
          if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
          end
          if (rem_q <= srfc_pkg::REM_W'(1)) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          if (rx_byte_i != sum_q) begin
            go_idle = 1'b1;
          end else begin
            store       = 1'b1;
            cmd_o.valid = 1'b1;
            cmd_o.bank  = bank_q;
            cmd_o.count = wp_q + 1'b1;
            bank_d      = ~bank_q;
            phase_d     = PH_T_SYNC1;
          end
        end
        PH_T_SYNC1: begin
          if (rx_byte_i == cfg_i.sync_first) phase_d = PH_T_SYNC2;
          else go_idle = 1'b1;
        end
        PH_T_SYNC2: begin
          if (rx_byte_i == cfg_i.sync_second) phase_d = PH_T_MODE;
          else go_idle = 1'b1;
        end
        PH_T_MODE: begin
          if (rx_byte_i == cfg_i.mode_trailing) phase_d = PH_T_LEN;
          else go_idle = 1'b1;
        end
        PH_T_LEN: begin
          rem_d   = srfc_pkg::REM_W'(rx_byte_i) + srfc_pkg::REM_W'(1);
          phase_d = PH_T_BODY;
        end
        PH_T_BODY: begin
          if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
          end
          if (rem_q <= srfc_pkg::REM_W'(1)) begin
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
    end
    if (store) begin
      sum_d = sum_q + rx_byte_i;
      if (room) begin
        wp_d = wp_q + 1'b1;
      end
    end
    // sync_first in the header: position 0 keeps the earlier sync byte
    if (restart) begin
      phase_d = PH_SYNC2;
      wp_d    = srfc_pkg::WP_W'(1);
      sum_d   = first_q;
    end
    if (go_idle) begin
      phase_d = PH_HUNT;
      wp_d    = '0;
      rem_d   = '0;
      sum_d   = '0;
    end
  end

  assign wr_o.en   = store && room;
  assign wr_o.addr = {bank_q, wp_q[srfc_pkg::POS_W-1:0]};
  assign wr_o.data = rx_byte_i;
  assign bank_o    = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      wp_q    <= '0;
      rem_q   <= '0;
      sum_q   <= '0;
      first_q <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      wp_q    <= wp_d;
      rem_q   <= rem_d;
      sum_q   <= sum_d;
      first_q <= first_d;
      bank_q  <= bank_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/srfc_cmdq.sv
// Short queue of drain requests between the parser and the drain engine.
`default_nettype none
module srfc_cmdq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire srfc_pkg::cmd_t push_i,
  input  wire logic           pop_i,
  output srfc_pkg::cmd_t      head_o,
  output logic                empty_o
);

  srfc_pkg::cmd_t                 entry_q [srfc_pkg::CMDQ_DEPTH];
  logic [srfc_pkg::CQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [srfc_pkg::CQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!push_i.valid && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/srfc_back.sv
// Back end: reads a verified frame from the store and queues its bytes for output.
`default_nettype none
module srfc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srfc_pkg::cmd_t                cmd_i,
  input  wire logic                          cmd_empty_i,
  output logic                               cmd_pop_o,
  output logic                               rd_en_o,
  output logic [srfc_pkg::ADDR_W-1:0]        rd_addr_o,
  input  wire logic [7:0]                    rd_data_i,
  output srfc_pkg::done_t                    done_o,
  input  wire logic                          pop_i,
  output srfc_pkg::out_t                     out_o,
  output logic                               empty_o
);

  typedef enum logic {B_IDLE, B_READ} back_state_e;

  back_state_e                    state_q;
  logic                           bank_q;
  logic [srfc_pkg::WP_W-1:0]      cnt_q;
  logic [srfc_pkg::POS_W-1:0]     k_q;
  logic                           infl_q;
  logic [srfc_pkg::BYTE_POS_W-1:0] meta_pos_q;
  logic                           meta_last_q;
  srfc_pkg::out_t                 fifo_q [2];
  logic                           wr_ptr_q, rd_ptr_q;
  logic [1:0]                     occ_q;
  logic [2:0]                     total;
  logic                           issue, is_last, do_pop;

  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (occ_q == 2'd0);
  assign out_o   = fifo_q[rd_ptr_q];

  // keep queued plus in-flight bytes within the two output slots
  assign total   = 3'(occ_q) + 3'(infl_q);
  assign issue   = (state_q == B_READ) && ((total < 3'd2) || do_pop);
  assign is_last = (srfc_pkg::WP_W'(k_q) + 1'b1) == cnt_q;

  assign cmd_pop_o    = (state_q == B_IDLE) && !cmd_empty_i;
  assign rd_en_o      = issue;
  assign rd_addr_o    = {bank_q, k_q};
  assign done_o.valid = issue && is_last;
  assign done_o.bank  = bank_q;

  always_ff @(posedge clk_i) begin
    if (infl_q) begin
      fifo_q[wr_ptr_q] <= '{frame_byte: rd_data_i, byte_position: meta_pos_q,
                            last_byte: meta_last_q};
    end
    if (issue) begin
      meta_pos_q  <= srfc_pkg::BYTE_POS_W'(k_q);
      meta_last_q <= is_last;
    end
    if (cmd_pop_o) begin
      bank_q <= cmd_i.bank;
      cnt_q  <= cmd_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      k_q      <= '0;
      infl_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      occ_q    <= 2'd0;
    end else begin
      infl_q <= issue;
      if (infl_q) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (infl_q && !do_pop) occ_q <= occ_q + 2'd1;
      else if (!infl_q && do_pop) occ_q <= occ_q - 2'd1;
      case (state_q)
        B_IDLE: begin
          if (cmd_pop_o) begin
            state_q <= B_READ;
            k_q     <= '0;
          end
        end
        B_READ: begin
          if (issue) begin
            if (is_last) state_q <= B_IDLE;
            else k_q <= k_q + 1'b1;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sync_frame_receiver_checksum.sv
// Top level of the sync frame receiver with additive checksum.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | rx_byte_i
//  result   | empty / pop        | frame_byte_o, byte_position_o, last_byte_o
//  config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// The parser takes one byte per cycle; a byte stalls (full) only while the store
// bank it would fill still waits to be drained, two frames being held at most.
// A verified frame of n bytes drains at one result per cycle while results are
// popped, the first one after a registered store read; the single read port sets
// that rate. Reset returns to hunting with both banks free; no clearing pass.
// A stalled result keeps its bank busy, so the parser stalls once both banks wait.
`default_nettype none
`include "assert_macros.svh"
module sync_frame_receiver_checksum (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [7:0]                        rx_byte_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [7:0]                             frame_byte_o,
  output logic [srfc_pkg::BYTE_POS_W-1:0]        byte_position_o,
  output logic                                   last_byte_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [2:0]                        cfg_idx_i,
  input  wire logic [7:0]                        cfg_wdata_i
);

  srfc_pkg::cfg_t    cfg_q;
  srfc_pkg::ram_wr_t wr;
  srfc_pkg::cmd_t    cmd, cmd_head;
  srfc_pkg::done_t   done;
  srfc_pkg::out_t    res;
  logic [1:0]        busy_q, busy_d;
  logic              front_bank, accept, cmd_empty, cmd_pop;
  logic              rd_en;
  logic [srfc_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  assign full   = busy_q[front_bank];
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= srfc_pkg::SYNC_FIRST_RST;
      cfg_q.sync_second   <= srfc_pkg::SYNC_SECOND_RST;
      cfg_q.mode_checked  <= srfc_pkg::MODE_CHECKED_RST;
      cfg_q.mode_trailing <= srfc_pkg::MODE_TRAILING_RST;
      cfg_q.max_payload   <= srfc_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srfc_pkg::REG_SYNC_FIRST:    cfg_q.sync_first    <= cfg_wdata_i;
        srfc_pkg::REG_SYNC_SECOND:   cfg_q.sync_second   <= cfg_wdata_i;
        srfc_pkg::REG_MODE_CHECKED:  cfg_q.mode_checked  <= cfg_wdata_i;
        srfc_pkg::REG_MODE_TRAILING: cfg_q.mode_trailing <= cfg_wdata_i;
        srfc_pkg::REG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // a bank is owned by the drain side from checksum match until its last read
  always_comb begin
    busy_d = busy_q;
    if (cmd.valid) busy_d[cmd.bank] = 1'b1;
    if (done.valid) busy_d[done.bank] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= '0;
    else busy_q <= busy_d;
  end

  srfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .wr_o       (wr),
    .cmd_o      (cmd),
    .bank_o     (front_bank)
  );

  srfc_ram #(
    .WIDTH (8),
    .DEPTH (srfc_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  srfc_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd),
    .pop_i   (cmd_pop),
    .head_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  srfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .done_o      (done),
    .pop_i       (pop),
    .out_o       (res),
    .empty_o     (empty)
  );

  assign frame_byte_o    = res.frame_byte;
  assign byte_position_o = res.byte_position;
  assign last_byte_o     = res.last_byte;

  `ASSERT_IMPLY(a_cmd_free_bank, clk_i, rst_ni, cmd.valid, !busy_q[cmd.bank])
  `ASSERT_IMPLY(a_done_busy_bank, clk_i, rst_ni, done.valid, busy_q[done.bank])
  `ASSERT_NEVER(a_no_write_busy, clk_i, rst_ni, wr.en && busy_q[wr.addr[srfc_pkg::ADDR_W-1]])

endmodule
`default_nettype wire

>>> sim/frame_check.sv
// Predicts the verified frame bytes of the receiver and compares them with its output.
`timescale 1ns / 100ps

module frame_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic [7:0]                      frame_byte_i,
  input  logic [srfc_pkg::BYTE_POS_W-1:0] byte_position_i,
  input  logic                            last_byte_i,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i,
  output int                              mismatch_count_o,
  output int                              outstanding_o
);
  import srfc_pkg::*;

  localparam int PAYLOAD_CAP = MAX_FRAME - 5;

  typedef enum logic [3:0] {
    HUNT, SYNC2, MODE, LENGTH, PAYLOAD, CHECKSUM,
    T_SYNC1, T_SYNC2, T_MODE, T_LENGTH, T_BODY
  } rx_phase_e;

  logic [7:0] sync_first, sync_second, mode_checked, mode_trailing;
  logic [3:0] payload_limit;

  rx_phase_e  phase;
  logic [7:0] frame_mem [MAX_FRAME];
  int         fill;
  int         remaining;
  logic [7:0] running_sum;

  out_t verified_bytes_due[$];
  int   mismatches = 0;

  task automatic store_rx_byte(input logic [7:0] b);
    if (fill < MAX_FRAME) begin
      frame_mem[fill] = b;
      fill++;
    end
  endtask

  task automatic abandon_frame();
    phase = HUNT;
    fill = 0;
    remaining = 0;
    running_sum = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int   k;
    int   cap;
    out_t item;
    cap = (payload_limit > PAYLOAD_CAP) ? PAYLOAD_CAP : payload_limit;
    case (phase)
      HUNT: begin
        if (b == sync_first) begin
          store_rx_byte(b);
          phase = SYNC2;
        end
      end
      SYNC2: begin
        if (b == sync_second) begin
          store_rx_byte(b);
          phase = MODE;
        end else if (b != sync_first) begin
          abandon_frame();
        end
      end
      MODE: begin
        // a fresh first sync restarts the header, keeping the stored one
        if (b == sync_first) begin
          phase = SYNC2;
          fill = 1;
        end else if (b == mode_checked) begin
          store_rx_byte(b);
          phase = LENGTH;
        end else begin
          abandon_frame();
        end
      end
      LENGTH: begin
        if (b == sync_first) begin
          phase = SYNC2;
          fill = 1;
        end else if (b == 8'd0 || int'(b) > cap) begin
          abandon_frame();
        end else begin
          store_rx_byte(b);
          remaining = b;
          phase = PAYLOAD;
        end
      end
      PAYLOAD: begin
        store_rx_byte(b);
        if (remaining > 0) begin
          remaining--;
          running_sum = running_sum + b;
        end
        // fold in the four header bytes once the payload is complete
        if (remaining == 0) begin
          running_sum = frame_mem[0] + frame_mem[1] + frame_mem[2] + frame_mem[3]
                        + running_sum;
          phase = CHECKSUM;
        end
      end
      CHECKSUM: begin
        if (b != running_sum) begin
          abandon_frame();
        end else begin
          store_rx_byte(b);
          for (k = 0; k < fill; k++) begin
            item.frame_byte    = frame_mem[k];
            item.byte_position = k[BYTE_POS_W-1:0];
            item.last_byte     = (k + 1 == fill);
            verified_bytes_due.push_back(item);
          end
          phase = T_SYNC1;
        end
      end
      T_SYNC1: begin
        if (b == sync_first) phase = T_SYNC2;
        else abandon_frame();
      end
      T_SYNC2: begin
        if (b == sync_second) phase = T_MODE;
        else abandon_frame();
      end
      T_MODE: begin
        if (b == mode_trailing) phase = T_LENGTH;
        else abandon_frame();
      end
      T_LENGTH: begin
        remaining = int'(b) + 1;
        phase = T_BODY;
      end
      T_BODY: begin
        if (remaining > 0) remaining--;
        if (remaining == 0) abandon_frame();
      end
      default: abandon_frame();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got;
    out_t want;
    if (!rst_ni) begin
      sync_first    = SYNC_FIRST_RST;
      sync_second   = SYNC_SECOND_RST;
      mode_checked  = MODE_CHECKED_RST;
      mode_trailing = MODE_TRAILING_RST;
      payload_limit = MAX_PAYLOAD_RST;
      abandon_frame();
      verified_bytes_due.delete();
      outstanding_o    <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (pop_i && !empty_i) begin
        got.frame_byte    = frame_byte_i;
        got.byte_position = byte_position_i;
        got.last_byte     = last_byte_i;
        if (verified_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected frame byte %02h at position %0d, last %0b",
                     $time, got.frame_byte, got.byte_position, got.last_byte);
        end else begin
          want = verified_bytes_due.pop_front();
          if (got.frame_byte !== want.frame_byte ||
              got.byte_position !== want.byte_position ||
              got.last_byte !== want.last_byte) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: frame byte mismatch: expected %02h pos %0d last %0b, got %02h pos %0d last %0b",
                       $time, want.frame_byte, want.byte_position, want.last_byte,
                       got.frame_byte, got.byte_position, got.last_byte);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SYNC_FIRST:    sync_first    = cfg_wdata_i;
          REG_SYNC_SECOND:   sync_second   = cfg_wdata_i;
          REG_MODE_CHECKED:  mode_checked  = cfg_wdata_i;
          REG_MODE_TRAILING: mode_trailing = cfg_wdata_i;
          REG_MAX_PAYLOAD:   payload_limit = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) parse_rx_byte(rx_byte_i);
      outstanding_o    <= verified_bytes_due.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> sim/sync_frame_receiver_checksum_test.sv
// Stimulus and verdict for the sync frame receiver with additive checksum.
`timescale 1ns / 100ps

module sync_frame_receiver_checksum_test;
  import srfc_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_SLACK  = 8;
  localparam int RANDOM_BYTES = 300;
  localparam int PAYLOAD_CAP  = MAX_FRAME - 5;

  typedef enum int {FLAW_NONE, FLAW_CHECKSUM, FLAW_HEADER, FLAW_LENGTH, FLAW_TRAILER}
    frame_flaw_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            rx_byte = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            frame_byte;
  logic [BYTE_POS_W-1:0] byte_position;
  logic                  last_byte;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_idx = '0;
  logic [7:0]            cfg_wdata = '0;

  int mismatch_count;
  int outstanding;
  int quiet_cycles = 0;
  int counted_bytes = 0;
  bit source_steady = 1'b0;
  bit sink_steady = 1'b0;

  // register values as currently programmed, used to build frames
  logic [7:0] sync_a = SYNC_FIRST_RST;
  logic [7:0] sync_b = SYNC_SECOND_RST;
  logic [7:0] mode_chk = MODE_CHECKED_RST;
  logic [7:0] mode_trl = MODE_TRAILING_RST;
  logic [3:0] payload_max = MAX_PAYLOAD_RST;

  always #10 clk = ~clk;

  sync_frame_receiver_checksum uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte),
    .empty           (empty),
    .pop             (pop),
    .frame_byte_o    (frame_byte),
    .byte_position_o (byte_position),
    .last_byte_o     (last_byte),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  frame_check checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .rx_byte_i        (rx_byte),
    .empty_i          (empty),
    .pop_i            (pop),
    .frame_byte_i     (frame_byte),
    .byte_position_i  (byte_position),
    .last_byte_i      (last_byte),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int length_limit();
    return (payload_max > PAYLOAD_CAP) ? PAYLOAD_CAP : payload_max;
  endfunction

  // hold push until the transfer, then maybe idle
  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    if (counted) counted_bytes++;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [7:0] mc, input logic [7:0] mt,
                             input logic [3:0] mp);
    wait_drained();
    write_register(REG_SYNC_FIRST, sf);
    write_register(REG_SYNC_SECOND, ss);
    write_register(REG_MODE_CHECKED, mc);
    write_register(REG_MODE_TRAILING, mt);
    write_register(REG_MAX_PAYLOAD, {4'd0, mp});
    cfg_we <= 1'b0;
    sync_a = sf;
    sync_b = ss;
    mode_chk = mc;
    mode_trl = mt;
    payload_max = mp;
    source_steady = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
  endtask

  // checked frame, followed by its trailing frame unless the checked one is broken
  task automatic send_frame(input int len, input int trail_len, input frame_flaw_e flaw);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    int         pos;
    int         limit;
    bytes_q = {sync_a, sync_b, mode_chk, 8'(len)};
    if (flaw == FLAW_HEADER) begin
      pos = $urandom_range(1, 2);
      bytes_q[pos] = bytes_q[pos] ^ 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_LENGTH) begin
      limit = length_limit();
      bytes_q[3] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(limit + 1, 255));
    end
    repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (bytes_q[i]) sum = sum + bytes_q[i];
    if (flaw == FLAW_CHECKSUM) sum = sum ^ 8'($urandom_range(1, 255));
    bytes_q.push_back(sum);
    foreach (bytes_q[i]) send_byte(bytes_q[i], 1'b1);
    if (flaw == FLAW_NONE || flaw == FLAW_TRAILER) begin
      bytes_q = {sync_a, sync_b, mode_trl, 8'(trail_len)};
      if (flaw == FLAW_TRAILER) begin
        // a first sync inside the trailing header drops it as well
        pos = $urandom_range(0, 2);
        bytes_q[pos] = (pos > 0 && $urandom_range(0, 1)) ? sync_a
                                                         : bytes_q[pos] ^ 8'($urandom_range(1, 255));
      end
      foreach (bytes_q[i]) send_byte(bytes_q[i], 1'b1);
      repeat (trail_len + 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : sink_side
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = sink_steady ? 0 : pick_gap();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : source_side
    int          start;
    int          r;
    int          len;
    int          trail;
    int          limit;
    logic [3:0]  mp;
    frame_flaw_e flaw;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: shortest and longest frames, broken ones, header quirks
    send_frame(1, 0, FLAW_NONE);
    send_frame(12, 255, FLAW_NONE);
    send_frame(3, 0, FLAW_CHECKSUM);
    send_byte(sync_a, 1'b1);
    send_byte(sync_b, 1'b1);
    send_byte(mode_chk, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(sync_a, 1'b1);
    send_byte(sync_b, 1'b1);
    send_byte(mode_chk, 1'b1);
    send_byte(8'd13, 1'b1);
    send_byte(sync_a, 1'b1);
    send_frame(2, 0, FLAW_NONE);
    send_byte(sync_a, 1'b1);
    send_byte(sync_b, 1'b1);
    send_frame(1, 1, FLAW_NONE);
    send_byte(sync_a, 1'b1);
    send_byte(sync_b, 1'b1);
    send_byte(mode_chk, 1'b1);
    send_frame(1, 0, FLAW_NONE);
    send_byte(sync_a, 1'b1);
    send_byte(8'h00, 1'b1);
    send_frame(1, 0, FLAW_HEADER);
    send_frame(2, 0, FLAW_TRAILER);

    // register extremes, including a zero limit and one above the cap
    reconfigure(8'h00, 8'hFF, 8'hFF, 8'h00, 4'd1);
    send_frame(1, 3, FLAW_NONE);
    reconfigure(8'hFF, 8'h00, 8'h00, 8'hFF, 4'd12);
    send_frame(12, 0, FLAW_NONE);
    reconfigure(SYNC_FIRST_RST, SYNC_SECOND_RST, MODE_CHECKED_RST, MODE_TRAILING_RST, 4'd0);
    send_frame(1, 0, FLAW_NONE);
    reconfigure(SYNC_FIRST_RST, SYNC_SECOND_RST, MODE_CHECKED_RST, MODE_TRAILING_RST, 4'd15);
    send_frame(12, 0, FLAW_NONE);
    send_frame(4, 0, FLAW_LENGTH);

    start = counted_bytes;
    while (counted_bytes - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 11) == 0) begin
        mp = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 1) * 15)
                                         : 4'($urandom_range(1, 12));
        reconfigure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), mp);
      end
      limit = length_limit();
      len = (limit == 0) ? 1 : (($urandom_range(0, 4) == 0) ? limit : $urandom_range(1, limit));
      trail = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 6);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 3)) send_byte(sync_a, 1'b1);
      end else if (r < 18) begin
        send_byte(sync_a, 1'b1);
        send_byte(sync_b, 1'b1);
        if ($urandom_range(0, 1)) send_byte(mode_chk, 1'b1);
      end
      if (r >= 18 && r < 26) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        flaw = (r < 60) ? FLAW_NONE :
               (r < 70) ? FLAW_CHECKSUM :
               (r < 78) ? FLAW_HEADER :
               (r < 86) ? FLAW_LENGTH : FLAW_TRAILER;
        send_frame(len, trail, flaw);
      end
    end

    wait_drained();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/srfc_pkg.sv
rtl/core/srfc_ram.sv
rtl/core/srfc_front.sv
rtl/core/srfc_cmdq.sv
rtl/core/srfc_back.sv
rtl/core/sync_frame_receiver_checksum.sv
sim/frame_check.sv
sim/sync_frame_receiver_checksum_test.sv
